// File: src/gpost_pkg.sv
package gpost_pkg;

    localparam int MAX_GOALS        = 8;
    localparam int MAX_ACTIONS      = 8;
    localparam int DEF_NUM_GOALS    = 8;
    localparam int DEF_NUM_ACTIONS  = 8;

    localparam int DIV_NW           = 50;
    localparam int DIV_DW           = 36;
    localparam int MUL_W            = 32;

    localparam logic [2:0] CFG_RATIONALITY = 3'd0;
    localparam logic [2:0] CFG_KNOWN       = 3'd1;
    localparam logic [2:0] CFG_EFFECT      = 3'd2;
    localparam logic [2:0] CFG_PRIOR_LOW   = 3'd3;
    localparam logic [2:0] CFG_PRIOR_HIGH  = 3'd4;

    localparam logic [36:0] T_LIMIT        = 37'd491520;
    localparam logic [31:0] RECIP_5        = 32'd3355444;
    localparam int          TAYLOR_TERMS   = 12;
    localparam int          SQUARINGS      = 4;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MAX,
        S_G_START,
        S_T,
        S_D,
        S_DR,
        S_TM,
        S_TK,
        S_TKW,
        S_SQ,
        S_SQR,
        S_W,
        S_WR,
        S_G_NEXT,
        S_P,
        S_PW,
        S_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

endpackage

// File: src/gpost_mul.sv
module gpost_mul (
    input  logic                         i_clk,
    input  logic [gpost_pkg::MUL_W-1:0]  i_a,
    input  logic [gpost_pkg::MUL_W-1:0]  i_b,
    output logic [2*gpost_pkg::MUL_W-1:0] o_prod
);

    logic [2*gpost_pkg::MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// File: src/gpost_div.sv
module gpost_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gpost_pkg::t_div_req i_req,
    output gpost_pkg::t_div_rsp o_rsp
);

    localparam int NW = gpost_pkg::DIV_NW;
    localparam int DW = gpost_pkg::DIV_DW;
    localparam int CW = $clog2(NW + 1);

    logic [DW:0]   r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   trial;
    logic          fits;

    assign trial = {r_rem[DW-1:0], r_quo[NW-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_rem  <= '0;
                r_quo  <= i_req.num;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
                r_quo <= {r_quo[NW-2:0], fits};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

endmodule

// File: src/goal_posterior_update_core.sv
// Channel   Direction  Handshake            Payload
// input     in         i_valid / o_stall    i_action, i_action_index
// result    out        o_valid / i_stall    o_goal_index, o_probability, o_last
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item at a time; o_stall is high from the accepting edge until the last result transfers.
// Per item: counts update and a pass over the goals finds the maximum; then per goal the weight
// is skipped at zero, zeroed when the exponent cuts off, else set by twelve series divisions.
// Each result needs one divide, or none when all weights are zero.
// Reset is synchronous: counts cleared, registers at their reset values.
// A stalled result holds; the block waits in the output state until it transfers.
module goal_posterior_update_core #(
    parameter int NUM_GOALS   = gpost_pkg::DEF_NUM_GOALS,
    parameter int NUM_ACTIONS = gpost_pkg::DEF_NUM_ACTIONS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [2:0]  i_action_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_goal_index,
    output logic [16:0] o_probability,
    output logic        o_last
);

    localparam int          MG    = gpost_pkg::MAX_GOALS;
    localparam logic [2:0]  G_END = 3'(NUM_GOALS - 1);

    gpost_pkg::t_state r_state, n_state;

    logic [15:0] r_rat;
    logic [7:0]  r_known;
    logic [63:0] r_effect;
    logic [63:0] r_pw_lo;
    logic [63:0] r_pw_hi;
    logic [15:0] r_cnt [MG];
    logic [31:0] r_num [MG];

    logic [2:0]         r_g;
    logic               r_any;
    logic [15:0]        r_cmax;
    logic [34:0]        r_total;
    logic [21:0]        r_dn;
    logic [29:0]        r_y;
    logic [30:0]        r_term;
    logic signed [32:0] r_sum;
    logic [3:0]         r_k;
    logic [30:0]        r_v;
    logic [1:0]         r_sq;
    logic [16:0]        r_e;
    logic [16:0]        r_p;

    logic [31:0]              mul_a, mul_b;
    logic [63:0]              prod;
    gpost_pkg::t_div_req      div_req;
    gpost_pkg::t_div_rsp      div_rsp;

    logic [15:0]        w_g;
    logic [15:0]        delta;
    logic [36:0]        t_val;
    logic               t_big;
    logic [30:0]        sq_v;
    logic signed [32:0] sum_nx;
    logic [30:0]        v_clamp;
    logic               in_fire;
    logic               out_fire;
    logic               act_known;

    assign w_g      = (r_g < 3'd4) ? 16'(r_pw_lo >> (16 * r_g[1:0]))
                                   : 16'(r_pw_hi >> (16 * r_g[1:0]));
    assign delta    = r_cmax - r_cnt[r_g];
    assign t_val    = {1'b0, prod[31:0], 4'b0} + {4'b0, prod[31:0], 1'b0}
                      + {5'b0, prod[31:0]};
    assign t_big    = t_val >= gpost_pkg::T_LIMIT;
    assign sq_v     = 31'((prod + 64'd536870912) >> 30);
    assign sum_nx   = r_k[0] ? (r_sum - $signed({2'b0, div_rsp.quo[30:0]}))
                             : (r_sum + $signed({2'b0, div_rsp.quo[30:0]}));
    assign v_clamp  = (sum_nx < 0) ? 31'd0
                    : (sum_nx > 33'sd1073741824) ? 31'd1073741824 : sum_nx[30:0];
    assign in_fire  = i_valid && !o_stall;
    assign out_fire = o_valid && !i_stall;
    assign act_known = (4'(i_action_index) < 4'(NUM_ACTIONS)) && r_known[i_action_index];

    gpost_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    gpost_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gpost_pkg::S_IDLE:    if (i_valid) n_state = gpost_pkg::S_MAX;
            gpost_pkg::S_MAX:     if (r_g == G_END) n_state = gpost_pkg::S_G_START;
            gpost_pkg::S_G_START: n_state = (w_g == 16'd0) ? gpost_pkg::S_G_NEXT : gpost_pkg::S_T;
            gpost_pkg::S_T:       n_state = t_big ? gpost_pkg::S_W : gpost_pkg::S_D;
            gpost_pkg::S_D:       n_state = gpost_pkg::S_DR;
            gpost_pkg::S_DR:      n_state = gpost_pkg::S_TM;
            gpost_pkg::S_TM:      n_state = gpost_pkg::S_TK;
            gpost_pkg::S_TK:      n_state = gpost_pkg::S_TKW;
            gpost_pkg::S_TKW: begin
                if (div_rsp.done) begin
                    n_state = (r_k == 4'(gpost_pkg::TAYLOR_TERMS)) ? gpost_pkg::S_SQ
                                                                    : gpost_pkg::S_TM;
                end
            end
            gpost_pkg::S_SQ:      n_state = gpost_pkg::S_SQR;
            gpost_pkg::S_SQR: begin
                n_state = (r_sq == 2'(gpost_pkg::SQUARINGS - 1)) ? gpost_pkg::S_W
                                                                 : gpost_pkg::S_SQ;
            end
            gpost_pkg::S_W:       n_state = gpost_pkg::S_WR;
            gpost_pkg::S_WR:      n_state = gpost_pkg::S_G_NEXT;
            gpost_pkg::S_G_NEXT:  n_state = (r_g == G_END) ? gpost_pkg::S_P : gpost_pkg::S_G_START;
            gpost_pkg::S_P:       n_state = (r_total == '0) ? gpost_pkg::S_OUT : gpost_pkg::S_PW;
            gpost_pkg::S_PW:      if (div_rsp.done) n_state = gpost_pkg::S_OUT;
            gpost_pkg::S_OUT: begin
                if (!i_stall) n_state = (r_g == G_END) ? gpost_pkg::S_IDLE : gpost_pkg::S_P;
            end
            default:              n_state = gpost_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        mul_a         = '0;
        mul_b         = '0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        o_stall       = (r_state != gpost_pkg::S_IDLE);
        o_valid       = (r_state == gpost_pkg::S_OUT);
        unique case (r_state)
            gpost_pkg::S_G_START: begin
                mul_a = {16'b0, r_rat};
                mul_b = {16'b0, delta};
            end
            gpost_pkg::S_D: begin
                mul_a = {10'b0, r_dn};
                mul_b = gpost_pkg::RECIP_5;
            end
            gpost_pkg::S_TM: begin
                mul_a = {1'b0, r_term};
                mul_b = {2'b0, r_y};
            end
            gpost_pkg::S_TK: begin
                div_req.start = 1'b1;
                div_req.num   = {18'b0, prod[61:30]};
                div_req.den   = {32'b0, r_k};
            end
            gpost_pkg::S_SQ: begin
                mul_a = {1'b0, r_v};
                mul_b = {1'b0, r_v};
            end
            gpost_pkg::S_W: begin
                mul_a = {16'b0, w_g};
                mul_b = {15'b0, r_e};
            end
            gpost_pkg::S_P: begin
                div_req.start = (r_total != '0);
                div_req.num   = {2'b0, r_num[r_g], 16'b0} + {16'b0, r_total[34:1]};
                div_req.den   = {1'b0, r_total};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gpost_pkg::S_IDLE;
            r_rat    <= 16'd4096;
            r_known  <= '0;
            r_effect <= '0;
            r_pw_lo  <= '0;
            r_pw_hi  <= '0;
            r_g      <= '0;
            for (int g = 0; g < MG; g++) r_cnt[g] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    gpost_pkg::CFG_RATIONALITY: r_rat    <= i_cfg_data[15:0];
                    gpost_pkg::CFG_KNOWN:       r_known  <= i_cfg_data[7:0];
                    gpost_pkg::CFG_EFFECT:      r_effect <= i_cfg_data;
                    gpost_pkg::CFG_PRIOR_LOW:   r_pw_lo  <= i_cfg_data;
                    gpost_pkg::CFG_PRIOR_HIGH:  r_pw_hi  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                gpost_pkg::S_IDLE: begin
                    if (in_fire) begin
                        for (int g = 0; g < MG; g++) begin
                            if (i_action) begin
                                r_cnt[g] <= '0;
                            end else if (act_known && g < NUM_GOALS
                                         && r_effect[{i_action_index, 3'(g)}]
                                         && r_cnt[g] != 16'hFFFF) begin
                                r_cnt[g] <= r_cnt[g] + 1'b1;
                            end
                        end
                        r_g    <= '0;
                        r_any  <= 1'b0;
                        r_cmax <= '0;
                    end
                end
                gpost_pkg::S_MAX: begin
                    if (w_g != 16'd0 && (!r_any || r_cnt[r_g] > r_cmax)) begin
                        r_cmax <= r_cnt[r_g];
                        r_any  <= 1'b1;
                    end
                    r_g     <= (r_g == G_END) ? 3'd0 : r_g + 1'b1;
                    r_total <= '0;
                end
                gpost_pkg::S_G_START: begin
                    if (w_g == 16'd0) r_num[r_g] <= '0;
                end
                gpost_pkg::S_T: begin
                    if (t_big) r_e <= '0;
                    else r_dn <= {t_val[18:0], 3'b0} + 22'd2;
                end
                gpost_pkg::S_DR: begin
                    r_y    <= {prod[43:24], 10'b0};
                    r_term <= 31'd1073741824;
                    r_sum  <= 33'sd1073741824;
                    r_k    <= 4'd1;
                end
                gpost_pkg::S_TKW: begin
                    if (div_rsp.done) begin
                        r_term <= div_rsp.quo[30:0];
                        r_sum  <= sum_nx;
                        r_k    <= r_k + 1'b1;
                        r_v    <= v_clamp;
                        r_sq   <= '0;
                    end
                end
                gpost_pkg::S_SQR: begin
                    r_v  <= sq_v;
                    r_sq <= r_sq + 1'b1;
                    r_e  <= 17'(({1'b0, sq_v} + 32'd8192) >> 14);
                end
                gpost_pkg::S_WR: begin
                    r_num[r_g] <= prod[31:0];
                    r_total    <= r_total + {3'b0, prod[31:0]};
                end
                gpost_pkg::S_G_NEXT: begin
                    r_g <= (r_g == G_END) ? 3'd0 : r_g + 1'b1;
                end
                gpost_pkg::S_P: begin
                    if (r_total == '0) r_p <= '0;
                end
                gpost_pkg::S_PW: begin
                    if (div_rsp.done) r_p <= div_rsp.quo[16:0];
                end
                gpost_pkg::S_OUT: begin
                    if (!i_stall) r_g <= (r_g == G_END) ? 3'd0 : r_g + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_goal_index  = r_g;
    assign o_probability = r_p;
    assign o_last        = (r_g == G_END);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> o_stall)
        else $error("block still ready after taking an item");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && o_last |=> !o_valid && !o_stall)
        else $error("block not idle after the final result");
    a_no_result_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |-> !o_valid)
        else $error("result offered while accepting input");
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_probability <= 17'd65536)
        else $error("probability above one");

endmodule
